### design/assert_macros.svh
// Assertion macros shared by the homography transform RTL.
// Depends on nothing; include after clk and rst_n are declared.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Check a property in the cycle after its trigger.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

### design/hpt_pkg.sv
// Package for the homography point transform: widths, pipeline word types.
// Depends on nothing.
`timescale 1ns / 1ps
package hpt_pkg;
    localparam int CW = 32;
    // Row sums are below 2^66 in magnitude; keep 68 bits signed.
    localparam int SW = 68;
    // Magnitudes of row sums.
    localparam int MW = 67;
    // Quotient bits kept: 33 value bits plus one sticky bit.
    localparam int QB = 33;

    typedef struct packed {
        logic [MW+CW-1:0] ux_rem;
        logic [MW+CW-1:0] vy_rem;
        logic [MW-1:0]    den;
        logic [QB-1:0]    qu;
        logic [QB-1:0]    qv;
        logic             su;
        logic             sv;
        logic             neg_u;
        logic             neg_v;
        logic             inf;
    } div_word_t;
endpackage

### design/hpt_div_cell.sv
// One restoring-division cell: produces one quotient bit for u and v.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
module hpt_div_cell #(
    parameter int BIT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  hpt_pkg::div_word_t din,
    output logic               vout,
    output hpt_pkg::div_word_t dout
);
    import hpt_pkg::*;

    localparam int RW = MW + CW;

    logic      v_reg;
    div_word_t d_reg;
    div_word_t d_next;
    logic [RW:0] du;
    logic [RW:0] dv;
    logic [RW:0] sh;

    // Subtract the shifted divisor from both remainders
    always_comb
    begin
        d_next = din;
        sh = {1'b0, din.den, {CW{1'b0}}} >> (CW - BIT);
        du = {1'b0, din.ux_rem} - sh;
        dv = {1'b0, din.vy_rem} - sh;
        d_next.qu[BIT] = ~du[RW];
        d_next.qv[BIT] = ~dv[RW];
        if (!du[RW])
        begin
            d_next.ux_rem = du[RW-1:0];
        end
        if (!dv[RW])
        begin
            d_next.vy_rem = dv[RW-1:0];
        end
    end

    // Advance the word when the pipe moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule

### design/homography_point_transform_top.sv
// Top level of the homography point transform: config, row sums, divider chain.
// Depends on hpt_pkg, hpt_div_cell and assert_macros.svh.
//
// Usage: write the five coefficient registers through wr_en/wr_index/wr_data
// while idle. Present points on in_valid/in_x/in_y; a word is taken when
// in_valid is high and in_stall low. Results leave on out_valid with out_x,
// out_y, at_infinity and saturated; the receiver holds out_stall to pause.
// Throughput: one point per cycle while in_stall is low. Pipeline: product, row sum,
// magnitude and range-check stages, 33 divider cells, one output stage; most
// of the pipeline is the chain of one-bit division cells.
// Reset loads the identity matrix and empties the pipeline. When the
// receiver stalls on a held result, the whole pipeline holds; in_stall follows out_stall
// only when the last stage holds a word, so the pipe keeps moving while
// the output stage is empty.
// Larger saturating quotients are detected by a sticky top-bit check.
`timescale 1ns / 1ps
module homography_point_transform_top #(
    parameter int COEF_FRAC_BITS  = 20,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic        at_infinity,
    output logic        saturated
);
    import hpt_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] R_C00 = 3'd0;
    localparam logic [2:0] R_C02 = 3'd1;
    localparam logic [2:0] R_C11 = 3'd2;
    localparam logic [2:0] R_C20 = 3'd3;
    localparam logic [2:0] R_C22 = 3'd4;
    localparam logic [31:0] C_ONE = 32'(64'd1 << COEF_FRAC_BITS);
    localparam int NST = 4;

    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [31:0] r4_reg;

    // Capture coefficient writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg <= {C_ONE, 32'd0};
            r1_reg <= 64'd0;
            r2_reg <= {C_ONE, 32'd0};
            r3_reg <= 64'd0;
            r4_reg <= C_ONE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                R_C00: r0_reg <= wr_data;
                R_C02: r1_reg <= wr_data;
                R_C11: r2_reg <= wr_data;
                R_C20: r3_reg <= wr_data;
                R_C22: r4_reg <= wr_data[31:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic last_v;
    assign en = !(last_v && out_stall);
    assign in_stall = !en;

    // Stage 1: six products
    logic signed [63:0] p_reg [6];
    logic signed [31:0] c [9];
    assign c[0] = r0_reg[63:32];
    assign c[1] = r0_reg[31:0];
    assign c[2] = r1_reg[63:32];
    assign c[3] = r1_reg[31:0];
    assign c[4] = r2_reg[63:32];
    assign c[5] = r2_reg[31:0];
    assign c[6] = r3_reg[63:32];
    assign c[7] = r3_reg[31:0];
    assign c[8] = r4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= c[0] * in_x;
            p_reg[1] <= c[3] * in_x;
            p_reg[2] <= c[6] * in_x;
            p_reg[3] <= c[1] * in_y;
            p_reg[4] <= c[4] * in_y;
            p_reg[5] <= c[7] * in_y;
        end
    end

    // Stage 2: row sums
    logic signed [SW-1:0] s_reg [3];
    logic signed [SW-1:0] s_next [3];
    always_comb
    begin
        s_next[0] = SW'(p_reg[0]) + SW'(p_reg[3])
                  + (SW'(c[2]) <<< COORD_FRAC_BITS);
        s_next[1] = SW'(p_reg[1]) + SW'(p_reg[4])
                  + (SW'(c[5]) <<< COORD_FRAC_BITS);
        s_next[2] = SW'(p_reg[2]) + SW'(p_reg[5])
                  + (SW'(c[8]) <<< COORD_FRAC_BITS);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    // Stage 3: magnitudes and signs, numerators prescaled
    div_word_t w0_reg;
    div_word_t w0_next;
    logic [MW-1:0] au, av, aw;
    always_comb
    begin
        au = MW'(s_reg[0][SW-1] ? -s_reg[0] : s_reg[0]);
        av = MW'(s_reg[1][SW-1] ? -s_reg[1] : s_reg[1]);
        aw = MW'(s_reg[2][SW-1] ? -s_reg[2] : s_reg[2]);
        w0_next = '0;
        w0_next.ux_rem = (MW+CW)'(au) << COORD_FRAC_BITS;
        w0_next.vy_rem = (MW+CW)'(av) << COORD_FRAC_BITS;
        w0_next.den = aw;
        w0_next.neg_u = s_reg[0][SW-1] ^ s_reg[2][SW-1];
        w0_next.neg_v = s_reg[1][SW-1] ^ s_reg[2][SW-1];
        w0_next.inf = (s_reg[2] == '0);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w0_reg <= w0_next;
        end
    end

    // Stage 4: sticky check for quotients of 2^33 or more
    div_word_t w1_reg;
    div_word_t w1_next;
    logic [MW+CW:0] big;
    assign big = {1'b0, w0_reg.den, {CW{1'b0}}} << 1;
    always_comb
    begin
        w1_next = w0_reg;
        w1_next.su = ({1'b0, w0_reg.ux_rem} >= big) && !w0_reg.inf;
        w1_next.sv = ({1'b0, w0_reg.vy_rem} >= big) && !w0_reg.inf;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= w1_next;
        end
    end

    // Chain of division cells, top bit first
    div_word_t cw [QB+1];
    logic [QB:0] cv;
    assign cw[0] = w1_reg;
    assign cv[0] = v_reg[3];
    for (genvar g = 0; g < QB; g++)
    begin : g_cell
        hpt_div_cell #(.BIT(QB - 1 - g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(cv[g]), .din(cw[g]), .vout(cv[g+1]), .dout(cw[g+1])
        );
    end

    // Valid bits for the front stages
    always_comb
    begin
        v_next = v_reg;
        v_next[0] = in_valid;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    // Output stage: sign, saturate, infinity
    div_word_t f;
    logic ov_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic inf_reg, sat_reg;
    logic [31:0] xo, yo;
    logic sx, sy;
    assign f = cw[QB];
    always_comb
    begin
        sx = f.su || (f.neg_u ? (f.qu > 33'h080000000) : (f.qu > 33'h07FFFFFFF));
        sy = f.sv || (f.neg_v ? (f.qv > 33'h080000000) : (f.qv > 33'h07FFFFFFF));
        if (sx)
            xo = f.neg_u ? 32'h80000000 : 32'h7FFFFFFF;
        else
            xo = f.neg_u ? -f.qu[31:0] : f.qu[31:0];
        if (sy)
            yo = f.neg_v ? 32'h80000000 : 32'h7FFFFFFF;
        else
            yo = f.neg_v ? -f.qv[31:0] : f.qv[31:0];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= cv[QB];
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= f.inf ? 32'd0 : xo;
            oy_reg <= f.inf ? 32'd0 : yo;
            inf_reg <= f.inf;
            sat_reg <= !f.inf && (sx || sy);
        end
    end

    assign last_v = ov_reg;
    assign out_valid = ov_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign at_infinity = inf_reg;
    assign saturated = sat_reg;

    // Checks
    `CHK_IMPL(a_stall_only_full, in_stall, out_valid && out_stall)
    `CHK_IMPL(a_inf_no_sat, out_valid && at_infinity, !saturated && out_x == 0)
    `CHK_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_x))
endmodule
